// ----- rtl/core/ctc_pkg.sv -----
// Package for the columnar transposition cipher: register indexes, widths,
// job and grid-write structs, and the letter test. No dependencies.
package ctc_pkg;

	// Default grid limits handed to the top level parameters
	localparam int DEF_MAX_ROW_COUNT = 8;
	localparam int DEF_MAX_COL_COUNT = 8;

	// Widths sized for the default grid limits (8 by 8)
	localparam int DIM_W  = 4;
	localparam int FILL_W = 7;
	localparam int ADDR_W = 6;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROW_COUNT = 2'd0;
	localparam logic [1:0] CFG_COL_COUNT = 2'd1;
	localparam logic [1:0] CFG_MODE      = 2'd2;

	// Mode codes
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// Fill character for unused cells
	localparam logic [7:0] PAD_CHAR = 8'h40;

	// What the back end has to do with a finished message
	typedef enum logic [2:0] {
		JOB_FAIL = 3'b001,
		JOB_ENC  = 3'b010,
		JOB_DEC  = 3'b100
	} job_kind_t;

	// One queued message: scan is outer count by inner count, address steps by step
	typedef struct packed {
		job_kind_t         kind;
		logic [DIM_W-1:0]  outer;
		logic [DIM_W-1:0]  inner;
		logic [DIM_W-1:0]  step;
		logic [FILL_W-1:0] fill;
	} job_t;

	// Grid write from the front end
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} grid_wr_t;

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

endpackage

// ----- rtl/core/ctc_front.sv -----
// Front end: configuration registers, byte loading and message classification.
// Depends on ctc_pkg.
module ctc_front #(
	parameter int MAX_ROW_COUNT = ctc_pkg::DEF_MAX_ROW_COUNT,
	parameter int MAX_COL_COUNT = ctc_pkg::DEF_MAX_COL_COUNT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [ctc_pkg::DIM_W-1:0]   cfg_data,
	output ctc_pkg::grid_wr_t           wr,
	output logic                        push,
	output ctc_pkg::job_t               job
);

	localparam int DW   = ctc_pkg::DIM_W;
	localparam int FW   = ctc_pkg::FILL_W;
	localparam int SW   = 2 * DW;
	localparam logic [DW-1:0] ROW_LIMIT = DW'(MAX_ROW_COUNT);
	localparam logic [DW-1:0] COL_LIMIT = DW'(MAX_COL_COUNT);

	logic [DW-1:0] row_count_q;
	logic [DW-1:0] col_count_q;
	logic          mode_q;
	logic [FW-1:0] fill_q;
	logic          ovf_q;

	logic [DW-1:0] rows;
	logic [DW-1:0] cols;
	logic [SW-1:0] size;
	logic          store;
	logic [FW-1:0] fill_nxt;
	logic          ovf_nxt;
	logic          enc_bad;
	logic          dec_bad;

	// Clamp grid size to the supported range
	always_comb begin
		rows = (row_count_q == '0) ? DW'(1) :
			((row_count_q > ROW_LIMIT) ? ROW_LIMIT : row_count_q);
		cols = (col_count_q == '0) ? DW'(1) :
			((col_count_q > COL_LIMIT) ? COL_LIMIT : col_count_q);
		size = SW'(rows) * SW'(cols);
	end

	// Decide store or drop, and classify the message on its last word
	always_comb begin
		store    = SW'(fill_q) < size;
		fill_nxt = store ? fill_q + FW'(1) : fill_q;
		ovf_nxt  = ovf_q | ~store;
		enc_bad  = ovf_nxt | (SW'(fill_nxt) > size);
		dec_bad  = ovf_nxt | (SW'(fill_nxt) != size);

		wr.en   = accept & store;
		wr.addr = fill_q[ctc_pkg::ADDR_W-1:0];
		wr.data = in_byte;

		push = accept & in_last;
		if (mode_q == ctc_pkg::MODE_DECRYPT) begin
			job.kind  = dec_bad ? ctc_pkg::JOB_FAIL : ctc_pkg::JOB_DEC;
			job.outer = rows;
			job.inner = cols;
			job.step  = rows;
		end else begin
			job.kind  = enc_bad ? ctc_pkg::JOB_FAIL : ctc_pkg::JOB_ENC;
			job.outer = cols;
			job.inner = rows;
			job.step  = cols;
		end
		job.fill = fill_nxt;
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= DW'(8);
			col_count_q <= DW'(8);
			mode_q      <= ctc_pkg::MODE_ENCRYPT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ctc_pkg::CFG_ROW_COUNT: row_count_q <= cfg_data;
				ctc_pkg::CFG_COL_COUNT: col_count_q <= cfg_data;
				ctc_pkg::CFG_MODE:      mode_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Advance fill count; clear it at the end of a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				fill_q <= fill_nxt;
				ovf_q  <= ovf_nxt;
			end
		end
	end

endmodule

// ----- rtl/core/ctc_queue.sv -----
// Two-entry job queue between front end and back end.
// Depends on ctc_pkg.
module ctc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ctc_pkg::job_t push_job,
	input  logic          pop,
	output ctc_pkg::job_t head,
	output logic          empty
);

	ctc_pkg::job_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (cnt_q == 2'd0);

	// Store pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/core/ctc_back.sv -----
// Back end: grid memory, readout scan, letter filter and result register.
// Depends on ctc_pkg.
module ctc_back #(
	parameter int MAX_ROW_COUNT = ctc_pkg::DEF_MAX_ROW_COUNT,
	parameter int MAX_COL_COUNT = ctc_pkg::DEF_MAX_COL_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctc_pkg::grid_wr_t wr,
	input  ctc_pkg::job_t     job,
	input  logic              job_valid,
	output logic              pop,
	output logic              busy,
	output logic              strobe,
	output logic [7:0]        out_byte,
	output logic              has_char,
	output logic              failed,
	output logic              out_last
);

	localparam int CELLS   = MAX_ROW_COUNT * MAX_COL_COUNT;
	localparam int GRID_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int DW      = ctc_pkg::DIM_W;
	localparam int FW      = ctc_pkg::FILL_W;
	localparam int SUM_W   = GRID_AW + DW;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	logic [7:0] grid_mem [CELLS];

	// Control state
	state_t        state_q, state_d;
	logic          valid_s1;
	logic          pend_v_q, pend_v_d;
	logic          strobe_q, strobe_d;

	// Job and scan payload
	logic          dec_q, dec_d;
	logic [DW-1:0] outer_q, outer_d;
	logic [DW-1:0] inner_q, inner_d;
	logic [DW-1:0] step_q, step_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [DW-1:0] oi_q, oi_d;
	logic [DW-1:0] ii_q, ii_d;
	logic [GRID_AW-1:0] addr_q, addr_d;
	logic [7:0]    rdata_s1;
	logic          pad_s1;
	logic          last_s1;
	logic [7:0]    pend_q, pend_d;
	logic [7:0]    byte_q, byte_d;
	logic          has_q, has_d;
	logic          fail_q, fail_d;
	logic          last_q, last_d;

	logic             rd_en;
	logic             last_inner;
	logic             last_outer;
	logic [SUM_W-1:0] addr_sum;

	assign rd_en      = (state_q == ST_SCAN);
	assign last_inner = (ii_q == inner_q - DW'(1));
	assign last_outer = (oi_q == outer_q - DW'(1));
	assign addr_sum   = SUM_W'(addr_q) + SUM_W'(step_q);
	assign pop        = (state_q == ST_IDLE) & job_valid;
	assign busy       = (state_q != ST_IDLE);

	assign strobe   = strobe_q;
	assign out_byte = byte_q;
	assign has_char = has_q;
	assign failed   = fail_q;
	assign out_last = last_q;

	// Write loaded bytes, read the scanned cell
	always_ff @(posedge clk) begin
		if (wr.en) begin
			grid_mem[wr.addr[GRID_AW-1:0]] <= wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= grid_mem[addr_q];
		end
	end

	// Sequence the job, filter letters, form results
	always_comb begin
		state_d  = state_q;
		pend_v_d = pend_v_q;
		strobe_d = 1'b0;
		dec_d    = dec_q;
		outer_d  = outer_q;
		inner_d  = inner_q;
		step_d   = step_q;
		fill_d   = fill_q;
		oi_d     = oi_q;
		ii_d     = ii_q;
		addr_d   = addr_q;
		pend_d   = pend_q;
		byte_d   = byte_q;
		has_d    = has_q;
		fail_d   = fail_q;
		last_d   = last_q;

		// Emit from the read stage
		if (valid_s1) begin
			if (!dec_q) begin
				strobe_d = 1'b1;
				byte_d   = pad_s1 ? ctc_pkg::PAD_CHAR : rdata_s1;
				has_d    = 1'b1;
				fail_d   = 1'b0;
				last_d   = last_s1;
			end else if (ctc_pkg::is_letter(rdata_s1)) begin
				if (pend_v_q) begin
					strobe_d = 1'b1;
					byte_d   = pend_q;
					has_d    = 1'b1;
					fail_d   = 1'b0;
					last_d   = 1'b0;
				end
				pend_d   = rdata_s1;
				pend_v_d = 1'b1;
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					unique case (job.kind) inside
						ctc_pkg::JOB_FAIL: begin
							strobe_d = 1'b1;
							byte_d   = 8'h00;
							has_d    = 1'b0;
							fail_d   = 1'b1;
							last_d   = 1'b1;
						end
						ctc_pkg::JOB_ENC, ctc_pkg::JOB_DEC: begin
							dec_d    = (job.kind == ctc_pkg::JOB_DEC);
							outer_d  = job.outer;
							inner_d  = job.inner;
							step_d   = job.step;
							fill_d   = job.fill;
							oi_d     = '0;
							ii_d     = '0;
							addr_d   = '0;
							pend_v_d = 1'b0;
							state_d  = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (last_inner) begin
					ii_d   = '0;
					oi_d   = oi_q + DW'(1);
					addr_d = GRID_AW'(oi_q + DW'(1));
					if (last_outer) begin
						state_d = ST_DRAIN;
					end
				end else begin
					ii_d   = ii_q + DW'(1);
					addr_d = addr_sum[GRID_AW-1:0];
				end
			end
			ST_DRAIN: begin
				if (valid_s1 && last_s1) begin
					state_d = dec_q ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				// Release the held letter as last, or an empty last word
				strobe_d = 1'b1;
				byte_d   = pend_v_q ? pend_q : 8'h00;
				has_d    = pend_v_q;
				fail_d   = 1'b0;
				last_d   = 1'b1;
				pend_v_d = 1'b0;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_s1 <= 1'b0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= rd_en;
			pend_v_q <= pend_v_d;
			strobe_q <= strobe_d;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		dec_q   <= dec_d;
		outer_q <= outer_d;
		inner_q <= inner_d;
		step_q  <= step_d;
		fill_q  <= fill_d;
		oi_q    <= oi_d;
		ii_q    <= ii_d;
		addr_q  <= addr_d;
		pad_s1  <= ~dec_q & (FW'(addr_q) >= fill_q);
		last_s1 <= last_inner & last_outer;
		pend_q  <= pend_d;
		byte_q  <= byte_d;
		has_q   <= has_d;
		fail_q  <= fail_d;
		last_q  <= last_d;
	end

endmodule

// ----- rtl/core/columnar_transposition_cipher.sv -----
// Top level of the columnar transposition cipher.
// Depends on ctc_pkg, ctc_front, ctc_queue and ctc_back.
//
//   channel   handshake                  payload
//   input     start, busy                in_byte, in_last
//   config    cfg_valid, cfg_ready       cfg_index, cfg_data
//   result    strobe (one cycle)         out_byte, has_char, failed, out_last
//
// Message bytes load one per cycle into the grid memory while busy is low.
// The last word queues a job; the back end takes it in the next cycle and
// scans rows*cols cells, one memory read per cycle. The final result passes
// the read stage and the result register, a decrypt also the flush state;
// busy stays high until the final result is registered.
// A failed length check gives its single result via queue and result register.
// Reset clears control state only; the grid needs no clearing.
// Results cannot be stalled by the receiver; cfg_ready is always high.
module columnar_transposition_cipher #(
	parameter int MAX_ROW_COUNT = ctc_pkg::DEF_MAX_ROW_COUNT,
	parameter int MAX_COL_COUNT = ctc_pkg::DEF_MAX_COL_COUNT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [ctc_pkg::DIM_W-1:0] cfg_data,
	output logic                      strobe,
	output logic [7:0]                out_byte,
	output logic                      has_char,
	output logic                      failed,
	output logic                      out_last
);

	ctc_pkg::grid_wr_t wr;
	ctc_pkg::job_t     front_job;
	ctc_pkg::job_t     head_job;
	logic              push;
	logic              pop;
	logic              q_empty;
	logic              back_busy;
	logic              accept;

	// Take a word only while no job is queued or running
	assign busy      = ~q_empty | back_busy;
	assign accept    = start & ~busy;
	assign cfg_ready = 1'b1;

	ctc_front #(
		.MAX_ROW_COUNT(MAX_ROW_COUNT),
		.MAX_COL_COUNT(MAX_COL_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr        (wr),
		.push      (push),
		.job       (front_job)
	);

	ctc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (pop),
		.head     (head_job),
		.empty    (q_empty)
	);

	ctc_back #(
		.MAX_ROW_COUNT(MAX_ROW_COUNT),
		.MAX_COL_COUNT(MAX_COL_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.job       (head_job),
		.job_valid (~q_empty),
		.pop       (pop),
		.busy      (back_busy),
		.strobe    (strobe),
		.out_byte  (out_byte),
		.has_char  (has_char),
		.failed    (failed),
		.out_last  (out_last)
	);

endmodule

// ----- rtl/core/ctc_checker.sv -----
// Port-level checks for the columnar transposition cipher, bound to the top.
// Depends on columnar_transposition_cipher.
module ctc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       in_last,
	input logic       strobe,
	input logic [7:0] out_byte,
	input logic       has_char,
	input logic       failed,
	input logic       out_last
);

	// A failed message gives one last word with no character
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && failed |-> out_last && !has_char)
		else $error("failed result without out_last or with a character");

	// A word without a character ends the message and carries zero
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !has_char |-> out_last && (out_byte == 8'h00))
		else $error("empty result is not a clean last word");

	// A non-final word causes no result
	a_quiet_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !in_last |=> !strobe)
		else $error("result after a non-final word");

	// The final word raises busy to block further input
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_last |=> busy)
		else $error("input open right after the final word");

endmodule

bind columnar_transposition_cipher ctc_checker u_ctc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.in_last  (in_last),
	.strobe   (strobe),
	.out_byte (out_byte),
	.has_char (has_char),
	.failed   (failed),
	.out_last (out_last)
);

// ----- tb/cipher_checker.sv -----
// Checker for the columnar transposition cipher: watches the input, register and
// result channels, predicts every result word and compares it. Depends on ctc_pkg.
module cipher_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [7:0]                in_byte,
	input  logic                      in_last,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [ctc_pkg::DIM_W-1:0] cfg_data,
	input  logic                      strobe,
	input  logic [7:0]                out_byte,
	input  logic                      has_char,
	input  logic                      failed,
	input  logic                      out_last,
	output int                        fail_count,
	output int                        chars_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW          = ctc_pkg::DIM_W;
	localparam int ROW_LIMIT   = ctc_pkg::DEF_MAX_ROW_COUNT;
	localparam int COL_LIMIT   = ctc_pkg::DEF_MAX_COL_COUNT;
	localparam int GRID_CELLS  = ROW_LIMIT * COL_LIMIT;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [7:0] ch;
		logic       has;
		logic       fail;
		logic       last;
	} cipher_out_t;

	// Predicted result words, oldest first
	cipher_out_t chars_owed[$];

	// Shadow of the registers and of the message being loaded
	logic [DW-1:0] rows_reg;
	logic [DW-1:0] cols_reg;
	logic          mode_reg;
	logic [7:0]    grid [GRID_CELLS];
	int            fill;
	bit            spilled;
	int            errors;

	function automatic int clamp_dim(logic [DW-1:0] v, int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	task automatic owe_char(logic [7:0] ch, logic has, logic fail);
		cipher_out_t w;
		w.ch   = ch;
		w.has  = has;
		w.fail = fail;
		w.last = 1'b0;
		chars_owed.push_back(w);
	endtask

	// Store one message word; on the last one, predict the whole burst
	task automatic take_char(logic [7:0] b, logic l);
		int rows;
		int cols;
		int size;
		int idx;
		int owed_at_start;
		cipher_out_t tail;
		rows = clamp_dim(rows_reg, ROW_LIMIT);
		cols = clamp_dim(cols_reg, COL_LIMIT);
		size = rows * cols;
		if (fill < size) begin
			grid[fill] = b;
			fill++;
		end else begin
			spilled = 1'b1;
		end
		if (!l)
			return;
		owed_at_start = chars_owed.size();
		if (mode_reg == ctc_pkg::MODE_ENCRYPT) begin
			if (spilled) begin
				owe_char(8'h00, 1'b0, 1'b1);
			end else begin
				// read column by column, pad cells past the message
				for (int c = 0; c < cols; c++) begin
					for (int r = 0; r < rows; r++) begin
						idx = r * cols + c;
						owe_char((idx < fill) ? grid[idx] : ctc_pkg::PAD_CHAR, 1'b1, 1'b0);
					end
				end
			end
		end else begin
			if (spilled || fill != size) begin
				owe_char(8'h00, 1'b0, 1'b1);
			end else begin
				// grid was filled column by column; read row by row, letters only
				for (int r = 0; r < rows; r++) begin
					for (int c = 0; c < cols; c++) begin
						idx = c * rows + r;
						if (is_alpha(grid[idx]))
							owe_char(grid[idx], 1'b1, 1'b0);
					end
				end
				if (chars_owed.size() == owed_at_start)
					owe_char(8'h00, 1'b0, 1'b0);
			end
		end
		// flag the final word of the burst
		tail = chars_owed.pop_back();
		tail.last = 1'b1;
		chars_owed.push_back(tail);
		fill    = 0;
		spilled = 1'b0;
	endtask

	task automatic check_char();
		cipher_out_t got;
		cipher_out_t want;
		got.ch   = out_byte;
		got.has  = has_char;
		got.fail = failed;
		got.last = out_last;
		if (chars_owed.size() == 0) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display({"%0t: unexpected result word: expected none, ",
					"got byte %h has_char %b failed %b out_last %b"},
					$time, got.ch, got.has, got.fail, got.last);
			return;
		end
		want = chars_owed.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display({"%0t: result word: expected byte %h has_char %b failed %b ",
					"out_last %b, got byte %h has_char %b failed %b out_last %b"},
					$time, want.ch, want.has, want.fail, want.last,
					got.ch, got.has, got.fail, got.last);
		end
	endtask

	// Follow every handshake at the clock edge that accepts it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = DW'(ROW_LIMIT);
			cols_reg = DW'(COL_LIMIT);
			mode_reg = ctc_pkg::MODE_ENCRYPT;
			fill     = 0;
			spilled  = 1'b0;
			errors   = 0;
			chars_owed.delete();
			fail_count <= 0;
			chars_due  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ctc_pkg::CFG_ROW_COUNT: rows_reg = cfg_data;
					ctc_pkg::CFG_COL_COUNT: cols_reg = cfg_data;
					ctc_pkg::CFG_MODE:      mode_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy)
				take_char(in_byte, in_last);
			if (strobe)
				check_char();
			fail_count <= errors;
			chars_due  <= chars_owed.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the cipher testbench: clock, reset, directed and random messages,
// register settings and the verdict. Depends on ctc_pkg, the cipher and cipher_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         ITEM_TARGET    = 460;
	localparam int         SETTLE_CYCLES  = 16;
	localparam int         TAIL_CYCLES    = 72;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam logic [1:0] CFG_SPARE      = 2'd3;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [7:0]                in_byte;
	logic                      in_last;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [1:0]                cfg_index;
	logic [ctc_pkg::DIM_W-1:0] cfg_data;
	logic                      strobe;
	logic [7:0]                out_byte;
	logic                      has_char;
	logic                      failed;
	logic                      out_last;
	int                        fail_count;
	int                        chars_due;
	int                        idle_pct;
	int                        quiet = 0;

	columnar_transposition_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.strobe    (strobe),
		.out_byte  (out_byte),
		.has_char  (has_char),
		.failed    (failed),
		.out_last  (out_last)
	);

	cipher_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.out_byte   (out_byte),
		.has_char   (has_char),
		.failed     (failed),
		.out_last   (out_last),
		.fail_count (fail_count),
		.chars_due  (chars_due)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// End the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic int eff_dim(logic [3:0] v);
		if (v == 0)
			return 1;
		return (v > 8) ? 8 : v;
	endfunction

	// Mostly small grids, now and then any register value
	function automatic logic [3:0] pick_dim();
		if ($urandom_range(9) < 7)
			return 4'($urandom_range(1, 4));
		return 4'($urandom_range(0, 15));
	endfunction

	// Favor letters so decrypt bursts carry output
	function automatic logic [7:0] pick_char();
		case ($urandom_range(4))
			0, 1:    return 8'("A" + $urandom_range(25));
			2:       return 8'("a" + $urandom_range(25));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Offer one message word, with a random gap first; hold until accepted
	task automatic send_char(logic [7:0] b, logic l);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		in_byte <= b;
		in_last <= l;
		do @(posedge clk); while (busy);
	endtask

	// Drop start and let the burst drain before touching registers
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (chars_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hold one register word until accepted; caller drops valid
	task automatic cfg_word(logic [1:0] idx, logic [3:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_grid(logic [3:0] rows, logic [3:0] cols, logic [3:0] mode_word);
		wait_idle();
		cfg_word(ctc_pkg::CFG_ROW_COUNT, rows);
		cfg_word(ctc_pkg::CFG_COL_COUNT, cols);
		cfg_word(ctc_pkg::CFG_MODE, mode_word);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int         sent;
		int         phase;
		int         size;
		int         len;
		logic [3:0] rows;
		logic [3:0] cols;
		logic [3:0] mode_word;

		arst_n    = 1'b0;
		start     = 1'b0;
		in_byte   = 8'h00;
		in_last   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 2'd0;
		cfg_data  = 4'd0;
		idle_pct  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid, 8 by 8 encrypt: one zero byte, the rest padding
		send_char(8'h00, 1'b1);

		// Row count 0 acts as 1, column count 15 as 8; upper mode bits ignored
		program_grid(4'd0, 4'd15, 4'b1110);
		send_char(8'hFF, 1'b0);
		send_char(8'h41, 1'b1);

		// One cell: overflow fails, a single byte passes
		program_grid(4'd1, 4'd1, {3'b001, ctc_pkg::MODE_ENCRYPT});
		send_char(8'h5A, 1'b0);
		send_char(8'h80, 1'b1);
		send_char(8'h7F, 1'b1);

		// Decrypt 2 by 2: letter bounds, then neighbors of the letter ranges
		program_grid(4'd2, 4'd2, {3'b000, ctc_pkg::MODE_DECRYPT});
		send_char(8'h41, 1'b0);
		send_char(8'h5A, 1'b0);
		send_char(8'h61, 1'b0);
		send_char(8'h7A, 1'b1);
		send_char(8'h40, 1'b0);
		send_char(8'h5B, 1'b0);
		send_char(8'h60, 1'b0);
		send_char(8'h7B, 1'b1);
		// short message fails the length check
		send_char(8'h61, 1'b1);

		// Decrypt one cell: too long, a letter, no letter
		program_grid(4'd1, 4'd1, {3'b101, ctc_pkg::MODE_DECRYPT});
		send_char("q", 1'b0);
		send_char("r", 1'b1);
		send_char("q", 1'b1);
		send_char("@", 1'b1);

		// Unused register index
		wait_idle();
		cfg_word(CFG_SPARE, 4'b0110);
		cfg_valid <= 1'b0;
		sent = 19;

		// Random phases: new grid and mode, then a few messages each
		phase = 0;
		while (sent < ITEM_TARGET) begin
			case (phase % 4)
				1:       idle_pct = 47;
				3:       idle_pct = 14;
				default: idle_pct = 0;
			endcase
			rows      = pick_dim();
			cols      = pick_dim();
			mode_word = 4'($urandom_range(15));
			program_grid(rows, cols, mode_word);
			size = eff_dim(rows) * eff_dim(cols);
			repeat (4) begin
				if ($urandom_range(9) == 0) begin
					// wrong length: short or past the grid
					if (size > 1 && $urandom_range(1) == 1)
						len = $urandom_range(1, size - 1);
					else
						len = size + $urandom_range(1, 2);
				end else if (mode_word[0] == ctc_pkg::MODE_DECRYPT) begin
					len = size;
				end else begin
					len = $urandom_range(1, size);
				end
				for (int i = 0; i < len; i++)
					send_char(pick_char(), i == len - 1);
				sent += len;
			end
			phase++;
		end

		// Drain the last burst, then allow stray words to show up
		start <= 1'b0;
		do @(posedge clk); while (chars_due != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ctc_pkg.sv
rtl/core/ctc_front.sv
rtl/core/ctc_queue.sv
rtl/core/ctc_back.sv
rtl/core/columnar_transposition_cipher.sv
rtl/core/ctc_checker.sv
tb/cipher_checker.sv
tb/testbench.sv
